FILE: design/sorted_value_table_unit_assert.svh
// Assertion macros shared by the sorted value table RTL
`ifndef SORTED_VALUE_TABLE_UNIT_ASSERT_SVH
`define SORTED_VALUE_TABLE_UNIT_ASSERT_SVH

// Checked on every clock edge except while reset is held
`define SVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define SVT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/svt_pkg.sv
// Shared types and constants for the sorted value table
package svt_pkg;

    localparam int SVT_CAPACITY = 64;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int COUNT_OUT_W  = 7;
    localparam int OUT_TDATA_W  = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_ODD    = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_REMOVE = 3'd2,
        CELL_MARK   = 3'd3,
        CELL_SWAP   = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
    } t_cell_ctrl;

endpackage

FILE: design/sorted_value_table_unit.sv
// Sorted value table top level: command sequencer, result register and cell chain
// Holds up to CAPACITY signed 32-bit values in ascending order in a chain of cells,
// one value per cell; every command returns one result with the success flag, the
// count, an empty flag and the smallest value. One command is in work at a time.
// Insert and remove go from acceptance to the result register in order: accept,
// locate the position across the chain, shift the chain, load the result. An
// unused command code skips the shift. Removing the odd values marks the discarded
// values, then the chain runs CAPACITY odd-even exchange rounds to push discarded
// slots to the tail, then the count steps down once per discarded value. On an
// empty table the odd removal skips the chain. A result is loaded only when the
// output register is empty or being read out. A new command is taken
// while an earlier result still waits in the output register.
`include "sorted_value_table_unit_assert.svh"

module sorted_value_table_unit
    import svt_pkg::*;
#(
    parameter int CAPACITY = SVT_CAPACITY
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [DATA_W-1:0]      i_s_tdata,   // [31:0] value
    input  logic [CMD_W-1:0]       i_s_tuser,   // [1:0] command
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [6:0] count, [7] empty_res, [39:8] smallest
    output logic                   o_m_tuser    // [0] success
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DECIDE  = 6'b000010,
        S_APPLY   = 6'b000100,
        S_COMPACT = 6'b001000,
        S_TRIM    = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state                   r_state, n_state;
    t_cmd                     r_cmd, n_cmd;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_ok, n_ok;
    logic [IW-1:0]            r_round, n_round;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_ok, n_out_ok;
    logic [COUNT_OUT_W-1:0]   r_out_count, n_out_count;
    logic                     r_out_empty, n_out_empty;
    logic signed [DATA_W-1:0] r_out_small, n_out_small;

    t_cell_ctrl               w_ctrl;
    logic signed [DATA_W-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]      w_ge;
    logic [CAPACITY-1:0]      w_drop;
    logic [CAPACITY-1:0]      w_hit;
    logic [CW-1:0]            w_last;
    logic                     w_last_drop;
    logic                     w_accept;

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_last      = r_count - CW'(1);
    assign w_last_drop = w_drop[w_last[IW-1:0]];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] nb_left_val, nb_right_val;
        logic                     nb_left_ge, nb_left_drop, nb_right_drop;

        if (g == 0) begin : g_head
            assign nb_left_val  = '0;
            assign nb_left_ge   = 1'b0;
            assign nb_left_drop = 1'b0;
        end else begin : g_left
            assign nb_left_val  = w_val[g-1];
            assign nb_left_ge   = w_ge[g-1];
            assign nb_left_drop = w_drop[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign nb_right_val  = '0;
            assign nb_right_drop = 1'b1;
        end else begin : g_right
            assign nb_right_val  = w_val[g+1];
            assign nb_right_drop = w_drop[g+1];
        end

        svt_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_value      (r_value),
            .i_count      (r_count),
            .i_left_val   (nb_left_val),
            .i_left_ge    (nb_left_ge),
            .i_left_drop  (nb_left_drop),
            .i_right_val  (nb_right_val),
            .i_right_drop (nb_right_drop),
            .o_val        (w_val[g]),
            .o_ge         (w_ge[g]),
            .o_drop       (w_drop[g]),
            .o_hit        (w_hit[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_value     = r_value;
        n_count     = r_count;
        n_ok        = r_ok;
        n_round     = r_round;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_ok    = r_out_ok;
        n_out_count = r_out_count;
        n_out_empty = r_out_empty;
        n_out_small = r_out_small;
        w_ctrl.op    = CELL_HOLD;
        w_ctrl.phase = r_round[0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = t_cmd'(i_s_tuser);
                    n_value = i_s_tdata;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_round = '0;
                unique case (r_cmd)
                    CMD_INSERT: begin
                        n_ok    = (r_count < CW'(CAPACITY));
                        n_state = S_APPLY;
                    end
                    CMD_REMOVE: begin
                        n_ok    = |w_hit;
                        n_state = S_APPLY;
                    end
                    CMD_ODD: begin
                        n_ok      = (r_count != '0);
                        w_ctrl.op = CELL_MARK;
                        n_state   = (r_count != '0) ? S_COMPACT : S_DONE;
                    end
                    default: begin
                        n_ok    = 1'b0;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_APPLY: begin
                if (r_ok) begin
                    if (r_cmd == CMD_INSERT) begin
                        w_ctrl.op = CELL_INSERT;
                        n_count   = r_count + CW'(1);
                    end else begin
                        w_ctrl.op = CELL_REMOVE;
                        n_count   = r_count - CW'(1);
                    end
                end
                n_state = S_DONE;
            end
            S_COMPACT: begin
                w_ctrl.op = CELL_SWAP;
                n_round   = r_round + IW'(1);
                if (r_round == IW'(CAPACITY - 1)) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                // kept values now form a prefix; drop the discarded tail one by one
                if (r_count != '0 && w_last_drop) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_count = COUNT_OUT_W'(r_count);
                    n_out_empty = (r_count == '0);
                    n_out_small = (r_count == '0) ? '0 : w_val[0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_value     <= n_value;
        r_ok        <= n_ok;
        r_round     <= n_round;
        r_out_ok    <= n_out_ok;
        r_out_count <= n_out_count;
        r_out_empty <= n_out_empty;
        r_out_small <= n_out_small;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_small, r_out_empty, r_out_count};
    assign o_m_tuser  = r_out_ok;

    `SVT_ASSERT_ALWAYS(a_count_zero_after_reset, $rose(i_rst_n) |-> (r_count == '0), "count not cleared by reset")
    `SVT_ASSERT(a_count_in_range, r_count <= CW'(CAPACITY), "count exceeds capacity")
    `SVT_ASSERT(a_accept_to_decide, w_accept |=> (r_state == S_DECIDE), "accepted command not decoded")
    `SVT_ASSERT(a_insert_grows, (r_state == S_APPLY && r_ok && r_cmd == CMD_INSERT) |=> (r_count == $past(r_count) + CW'(1)), "insert did not grow count")
    `SVT_ASSERT(a_trim_stops_on_kept, (r_state == S_DONE && r_cmd == CMD_ODD && r_count != '0) |-> !w_last_drop, "discarded value left inside table")

endmodule

FILE: design/svt_cell.sv
// One slot of the sorted value chain: value, drop mark and neighbour transfers
module svt_cell
    import svt_pkg::*;
#(
    parameter int CAPACITY = SVT_CAPACITY,
    parameter int IDX      = 0
) (
    input  logic                              i_clk,
    input  t_cell_ctrl                        i_ctrl,
    input  logic signed [DATA_W-1:0]          i_value,
    input  logic [$clog2(CAPACITY+1)-1:0]     i_count,
    input  logic signed [DATA_W-1:0]          i_left_val,
    input  logic                              i_left_ge,
    input  logic                              i_left_drop,
    input  logic signed [DATA_W-1:0]          i_right_val,
    input  logic                              i_right_drop,
    output logic signed [DATA_W-1:0]          o_val,
    output logic                              o_ge,
    output logic                              o_drop,
    output logic                              o_hit
);

    localparam int             CW        = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0]  POS       = CW'(IDX);
    localparam bit             HAS_LEFT  = (IDX > 0);
    localparam bit             HAS_RIGHT = (IDX < CAPACITY - 1);
    localparam logic           PAR       = ((IDX % 2) == 1);

    logic signed [DATA_W-1:0] r_val, n_val;
    logic                     r_drop, n_drop;
    logic                     w_live;
    logic                     w_ge;

    assign w_live = (POS < i_count);
    // not smaller than the search value, or past the end of the table
    assign w_ge   = !(w_live && (r_val < i_value));

    always_comb begin
        n_val  = r_val;
        n_drop = r_drop;
        unique case (i_ctrl.op)
            CELL_HOLD: begin
                n_val = r_val;
            end
            CELL_INSERT: begin
                if (w_ge) begin
                    n_val = (HAS_LEFT && i_left_ge) ? i_left_val : i_value;
                end
            end
            CELL_REMOVE: begin
                if (w_ge && HAS_RIGHT) begin
                    n_val = i_right_val;
                end
            end
            CELL_MARK: begin
                n_drop = !w_live || r_val[0];
            end
            CELL_SWAP: begin
                // odd-even transposition: dropped slots bubble to the tail
                if (i_ctrl.phase == PAR) begin
                    if (HAS_RIGHT && r_drop && !i_right_drop) begin
                        n_val  = i_right_val;
                        n_drop = i_right_drop;
                    end
                end else begin
                    if (HAS_LEFT && i_left_drop && !r_drop) begin
                        n_val  = i_left_val;
                        n_drop = i_left_drop;
                    end
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_drop <= n_drop;
    end

    assign o_val  = r_val;
    assign o_ge   = w_ge;
    assign o_drop = r_drop;
    assign o_hit  = w_ge && !(HAS_LEFT && i_left_ge) && w_live && (r_val == i_value);

endmodule

FILE: verif/testbench.sv
// Testbench for the sorted value table unit: directed table, random traffic, result checking
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import svt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int BLOCKS          = 15;
    localparam int BLOCK_ITEMS     = 102;
    localparam int HOLDOFF_CYCLES  = 500;
    localparam int DRAIN_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct {
        logic                   success;
        logic [COUNT_OUT_W-1:0] count;
        logic                   empty_res;
        logic [DATA_W-1:0]      smallest;
    } t_result;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
        bit                typed;
        t_result           want;
    } t_vector;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic [DATA_W-1:0]      i_s_tdata  = '0;
    logic [CMD_W-1:0]       i_s_tuser  = '0;
    logic                   i_m_tready = 1'b0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;

    logic signed [DATA_W-1:0] held_values[$];
    t_result                  pending_results[$];
    t_vector                  vectors[$];
    int                       errors        = 0;
    int                       send_idle_pct = 0;
    int                       recv_idle_pct = 0;
    int                       quiet_cycles  = 0;
    bit                       holdoff_req   = 1'b0;

    always #2 i_clk = ~i_clk;

    sorted_value_table_unit #(
        .CAPACITY(SVT_CAPACITY)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [31:0] value
        .i_s_tuser  (i_s_tuser),   // [1:0] command
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [6:0] count, [7] empty_res, [39:8] smallest
        .o_m_tuser  (o_m_tuser)    // [0] success
    );

    // Applies one command to the local copy of the table and returns the answer
    function automatic t_result table_after_command(input logic [CMD_W-1:0] cmd,
                                                    input logic signed [DATA_W-1:0] v);
        t_result                  r;
        int                       pos;
        logic signed [DATA_W-1:0] kept[$];
        r.success = 1'b0;
        pos = 0;
        while (pos < held_values.size() && held_values[pos] < v)
            pos++;
        case (cmd)
            CMD_INSERT: begin
                if (held_values.size() < SVT_CAPACITY) begin
                    held_values.insert(pos, v);
                    r.success = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (pos < held_values.size() && held_values[pos] == v) begin
                    held_values.delete(pos);
                    r.success = 1'b1;
                end
            end
            CMD_ODD: begin
                if (held_values.size() != 0) begin
                    foreach (held_values[i])
                        if (!held_values[i][0])
                            kept.push_back(held_values[i]);
                    held_values = kept;
                    r.success = 1'b1;
                end
            end
            default: ;
        endcase
        r.count     = COUNT_OUT_W'(held_values.size());
        r.empty_res = (held_values.size() == 0);
        r.smallest  = (held_values.size() == 0) ? '0 : held_values[0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                           input bit typed, input logic s, input int c, input logic e,
                           input logic [DATA_W-1:0] m);
        t_vector row;
        row.cmd   = cmd;
        row.value = value;
        row.typed = typed;
        row.want  = '{s, COUNT_OUT_W'(c), e, m};
        vectors.push_back(row);
    endtask

    // Offers one transaction; valid stays high afterwards unless the next call idles
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                             input bit typed, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        predicted = table_after_command(cmd, value);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic send_random(input int odd_pct, input int insert_pct);
        int                r;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
        t_result           none;
        none = '{default: '0};
        r = $urandom_range(99);
        if (r < odd_pct)
            cmd = CMD_ODD;
        else if (r < odd_pct + 2)
            cmd = CMD_UNUSED;
        else if (r < odd_pct + 2 + insert_pct)
            cmd = CMD_INSERT;
        else
            cmd = CMD_REMOVE;
        case ($urandom_range(3))
            0: value = $urandom();
            1: value = $urandom_range(16) - 8;   // small pool for duplicates
            2: value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: value = (held_values.size() != 0) ?
                             held_values[$urandom_range(held_values.size() - 1)] : $urandom();
        endcase
        // removes mostly hit a stored value so the table really drains
        if (cmd == CMD_REMOVE && held_values.size() != 0 && $urandom_range(99) < 70)
            value = held_values[$urandom_range(held_values.size() - 1)];
        send_item(cmd, value, 1'b0, none);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (holdoff_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(posedge i_clk);
                holdoff_req = 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", {o_m_tdata, o_m_tuser}, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tuser !== want.success)
                    report_mismatch("success", o_m_tuser, want.success);
                if (o_m_tdata[6:0] !== want.count)
                    report_mismatch("count", o_m_tdata[6:0], want.count);
                if (o_m_tdata[7] !== want.empty_res)
                    report_mismatch("empty_res", o_m_tdata[7], want.empty_res);
                if (o_m_tdata[39:8] !== want.smallest)
                    report_mismatch("smallest", o_m_tdata[39:8], want.smallest);
            end
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        add_row(CMD_ODD,    32'd0,         1, 1'b0, 0, 1'b1, 32'd0);
        add_row(CMD_REMOVE, 32'd5,         1, 1'b0, 0, 1'b1, 32'd0);
        add_row(CMD_UNUSED, 32'd0,         1, 1'b0, 0, 1'b1, 32'd0);
        add_row(CMD_INSERT, 32'h7FFF_FFFF, 1, 1'b1, 1, 1'b0, 32'h7FFF_FFFF);
        add_row(CMD_INSERT, 32'h8000_0000, 1, 1'b1, 2, 1'b0, 32'h8000_0000);
        add_row(CMD_INSERT, 32'd0,         1, 1'b1, 3, 1'b0, 32'h8000_0000);
        add_row(CMD_INSERT, 32'hFFFF_FFFF, 0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_INSERT, 32'hFFFF_FFFF, 0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_INSERT, 32'd2,         0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_REMOVE, 32'd12345,     1, 1'b0, 6, 1'b0, 32'h8000_0000);
        add_row(CMD_REMOVE, 32'h8000_0000, 1, 1'b1, 5, 1'b0, 32'hFFFF_FFFF);
        add_row(CMD_REMOVE, 32'hFFFF_FFFF, 0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_UNUSED, 32'hFFFF_FFFF, 0, 1'b0, 0, 1'b0, 32'd0);
        // odd sweep takes the negative odd value and the largest one
        add_row(CMD_ODD,    32'hFFFF_FFFF, 0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_ODD,    32'd0,         0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_REMOVE, 32'd0,         0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_REMOVE, 32'd2,         1, 1'b1, 0, 1'b1, 32'd0);
        add_row(CMD_INSERT, 32'hAAAA_AAAA, 0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_INSERT, 32'h5555_5555, 0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_REMOVE, 32'h5555_5556, 0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_INSERT, 32'h8000_0000, 0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_UNUSED, 32'h5555_5555, 0, 1'b0, 0, 1'b0, 32'd0);
        add_row(CMD_ODD,    32'd0,         0, 1'b0, 0, 1'b0, 32'd0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 8;
        recv_idle_pct = 47;

        foreach (vectors[i])
            send_item(vectors[i].cmd, vectors[i].value, vectors[i].typed, vectors[i].want);

        // blocks cycle through filling to capacity, churn and draining to empty
        for (int blk = 0; blk < BLOCKS; blk++) begin
            if (blk == 1)
                holdoff_req = 1'b1;
            if (blk == BLOCKS / 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 8;
            end
            if (blk == 2 * BLOCKS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                case (blk % 3)
                    0:       send_random(0, 90);
                    1:       send_random(5, 47);
                    default: send_random(3, 15);
                endcase
            end
        end
        i_s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
